[rtl/core/ltp_pkg.sv]
// Shared widths, codes and constants for the looping table player.
package ltp_pkg;

    // Fixed field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int ADDR_IN_W  = 14;
    localparam int SPEED_W    = 24;
    localparam int LEN_W      = 15;
    localparam int LSTART_W   = 14;
    localparam int LEND_W     = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Integer part of the phase: holds loop_end - 3 and loop_start + 1, signed
    localparam int IDX_W = LEND_W + 2;

    // Parameter defaults
    localparam int DEPTH_DEF = 16384;
    localparam int FRAC_DEF  = 16;

    // Register reset values
    localparam logic [LEN_W-1:0]    TABLE_LENGTH_RST = 15'd0;
    localparam logic [LSTART_W-1:0] LOOP_START_RST   = 14'd0;
    localparam logic [LEND_W-1:0]   LOOP_END_RST     = 15'd10000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END     = 2'd2;

    // Item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_PLAY  = 1'b1;

    // floor(h / 3) as (h * DIV3_MUL) >> DIV3_SHIFT, exact for h < 2**DIV3_IN_W
    localparam int               DIV3_IN_W  = 19;
    localparam int               DIV3_MUL_W = 20;
    localparam logic [19:0]      DIV3_MUL   = 20'd349526;
    localparam int               DIV3_SHIFT = 20;
    localparam int               Q3_W       = 18;

    // Output saturation limits
    localparam logic signed [SAMPLE_W-1:0] SMAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SMIN = 16'sh8000;

endpackage

[rtl/core/ltp_ram.sv]
// Generic single-port RAM with registered read data.
module ltp_ram #(
    parameter int WIDTH = ltp_pkg::SAMPLE_W,
    parameter int DEPTH = ltp_pkg::DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/ltp_cubic.sv]
// Ten-stage 4-point cubic interpolation datapath, one result held until taken.
module ltp_cubic #(
    parameter int FRAC_BITS = ltp_pkg::FRAC_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                take,
    input  logic signed [ltp_pkg::SAMPLE_W-1:0] a,
    input  logic signed [ltp_pkg::SAMPLE_W-1:0] b,
    input  logic signed [ltp_pkg::SAMPLE_W-1:0] c,
    input  logic signed [ltp_pkg::SAMPLE_W-1:0] d,
    input  logic [FRAC_BITS:0]                  f,
    output logic                                done,
    output logic signed [ltp_pkg::SAMPLE_W-1:0] y
);

    import ltp_pkg::*;

    localparam int SW   = SAMPLE_W;
    localparam int CBW  = SW + 1;          // c - b
    localparam int TW   = SW + 3;          // polynomial terms
    localparam int EW   = CBW + 3;         // cb - p3
    localparam int XW   = FRAC_BITS + 22;  // products scaled by S
    localparam int MW   = FRAC_BITS + 21;  // |p1|*(S-f) + 3S
    localparam int PMW  = 20;              // |p1|
    localparam int RW   = 22;              // rounded correction term
    localparam int YW   = RW + 1;
    localparam int NSTG = 9;

    localparam logic [XW-1:0]        HALF_X  = XW'(1) << (FRAC_BITS - 1);
    localparam logic signed [XW-1:0] HALF_P  = $signed(HALF_X);
    localparam logic signed [XW-1:0] HALF_N  = $signed(HALF_X - XW'(1));
    localparam logic [FRAC_BITS:0]   ONE_F   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [MW-1:0]        THREE_S = MW'(3) << FRAC_BITS;

    logic [NSTG-1:0]        vld_reg;
    logic                   done_reg;

    logic signed [SW-1:0]   b1_reg;
    logic signed [CBW-1:0]  cb1_reg;
    logic [FRAC_BITS:0]     f1_reg;
    logic signed [TW-1:0]   t1_reg, t2_reg;
    logic signed [XW-1:0]   x1_reg;
    logic                   neg_reg;
    logic [XW-1:0]          xa_reg;
    logic [PMW-1:0]         pm_reg;
    logic [MW-1:0]          m_reg;
    logic [Q3_W-1:0]        q_reg;
    logic signed [EW-1:0]   e_reg;
    logic signed [XW-1:0]   x5_reg;
    logic signed [RW-1:0]   r_reg;
    logic signed [SW-1:0]   y_reg;

    logic signed [CBW-1:0]  cb_next;
    logic signed [TW-1:0]   a_x, b_x, d_x, cb_x;
    logic signed [TW-1:0]   t1_next, t2_next;
    logic signed [XW-1:0]   x1_next;
    logic [XW-1:0]          xa_next, rnd_sum;
    logic [PMW-1:0]         pm_next;
    logic [FRAC_BITS:0]     omf;
    logic [MW-1:0]          m_next;
    logic [DIV3_IN_W-1:0]   h3;
    logic [DIV3_IN_W+DIV3_MUL_W-1:0] q_prod;
    logic [Q3_W-1:0]        q_next;
    logic signed [EW-1:0]   cb_e, q_e, e_next;
    logic signed [XW-1:0]   x5_next, r_sum;
    logic signed [RW-1:0]   r_next;
    logic signed [YW-1:0]   y_sum;
    logic                   y_ovf;
    logic signed [SW-1:0]   y_next;

    always_comb
    begin
        // stage 1: cb, d - a - 3cb, d + 2a - 3b
        cb_next = $signed({c[SW-1], c}) - $signed({b[SW-1], b});
        a_x     = $signed({{(TW-SW){a[SW-1]}}, a});
        b_x     = $signed({{(TW-SW){b[SW-1]}}, b});
        d_x     = $signed({{(TW-SW){d[SW-1]}}, d});
        cb_x    = $signed({{(TW-CBW){cb_next[CBW-1]}}, cb_next});
        t1_next = d_x - a_x - cb_x - (cb_x <<< 1);
        t2_next = d_x + (a_x <<< 1) - b_x - (b_x <<< 1);

        // stage 2: p1 numerator
        x1_next = t1_reg * $signed({1'b0, f1_reg}) + $signed({t2_reg, {FRAC_BITS{1'b0}}});

        // stages 3-4: p1 rounded on the magnitude
        xa_next = x1_reg[XW-1] ? $unsigned(-x1_reg) : $unsigned(x1_reg);
        rnd_sum = xa_reg + HALF_X;
        pm_next = rnd_sum[FRAC_BITS+PMW-1:FRAC_BITS];

        // stage 5: |p1|*(S-f) + 3S, half the divisor added for rounding
        omf    = ONE_F - f1_reg;
        m_next = pm_reg * omf + THREE_S;

        // stage 6: divide by 6S = shift by S and 2, then reciprocal of 3
        h3     = m_reg[FRAC_BITS+DIV3_IN_W:FRAC_BITS+1];
        q_prod = h3 * DIV3_MUL;
        q_next = q_prod[DIV3_SHIFT+Q3_W-1:DIV3_SHIFT];

        // stage 7: cb - p3, sign of p3 follows p1
        cb_e   = $signed({{(EW-CBW){cb1_reg[CBW-1]}}, cb1_reg});
        q_e    = $signed({{(EW-Q3_W){1'b0}}, q_reg});
        e_next = neg_reg ? cb_e + q_e : cb_e - q_e;

        // stage 8
        x5_next = e_reg * $signed({1'b0, f1_reg});

        // stage 9: round to nearest, ties away from zero
        r_sum  = x5_reg + (x5_reg[XW-1] ? HALF_N : HALF_P);
        r_next = r_sum[FRAC_BITS+RW-1:FRAC_BITS];

        // stage 10: add b and saturate
        y_sum  = $signed({{(YW-SW){b1_reg[SW-1]}}, b1_reg}) + $signed({r_reg[RW-1], r_reg});
        y_ovf  = !((&y_sum[YW-1:SW-1]) || !(|y_sum[YW-1:SW-1]));
        y_next = y_ovf ? (y_sum[YW-1] ? SMIN : SMAX) : y_sum[SW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= {vld_reg[NSTG-2:0], start};
            if (vld_reg[NSTG-1])
            begin
                done_reg <= 1'b1;
            end
            else if (take)
            begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            b1_reg  <= b;
            cb1_reg <= cb_next;
            f1_reg  <= f;
            t1_reg  <= t1_next;
            t2_reg  <= t2_next;
        end
        if (vld_reg[0])
        begin
            x1_reg <= x1_next;
        end
        if (vld_reg[1])
        begin
            xa_reg  <= xa_next;
            neg_reg <= x1_reg[XW-1];
        end
        if (vld_reg[2])
        begin
            pm_reg <= pm_next;
        end
        if (vld_reg[3])
        begin
            m_reg <= m_next;
        end
        if (vld_reg[4])
        begin
            q_reg <= q_next;
        end
        if (vld_reg[5])
        begin
            e_reg <= e_next;
        end
        if (vld_reg[6])
        begin
            x5_reg <= x5_next;
        end
        if (vld_reg[7])
        begin
            r_reg <= r_next;
        end
        if (vld_reg[8])
        begin
            y_reg <= y_next;
        end
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

[rtl/core/looping_table_player_cubic_interp_unit.sv]
// Looping table player: sample table, Q.F phase with loop wrap, 4-point cubic output.
//
// A write item (op 0) stores sample_in at address in a TABLE_DEPTH x 16 single-port
// table RAM in the cycle it is accepted and gives no result; addresses at or beyond
// TABLE_DEPTH are dropped. A play item (op 1) adds speed to the signed phase (FRAC_BITS
// fraction bits, reset 1.0), applies the loop checks (below loop_start+1 the phase
// jumps to loop_end-3, then above loop_end-3 it jumps to loop_start+1), clamps the
// integer part to 1..length-3, reads the four neighboring entries and gives one
// saturated Q1.15 cubic-interpolated sample. With table_length below 3 a play item
// gives zero and leaves the phase alone. A play item keeps in_stall high from
// acceptance through these steps in order: phase add, loop wrap, index clamp,
// 4 table reads through the single RAM port (registered read data, last word
// used directly), and the 10-stage interpolation pipeline; a short-table play
// item goes straight to its zero result. The finished sample sits in an output
// register, so a new item is accepted while it waits on out_stall; a play result
// only waits when the previous one has not been taken yet. The table has no reset:
// entries must be written before play reaches them. cfg_ready is always high;
// registers are meant to be written while no item is in flight.
module looping_table_player_cubic_interp_unit #(
    parameter int TABLE_DEPTH = ltp_pkg::DEPTH_DEF,
    parameter int FRAC_BITS   = ltp_pkg::FRAC_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ltp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ltp_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  op,
    input  logic [ltp_pkg::ADDR_IN_W-1:0]         address,
    input  logic signed [ltp_pkg::SAMPLE_W-1:0]   sample_in,
    input  logic signed [ltp_pkg::SPEED_W-1:0]    speed,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [ltp_pkg::SAMPLE_W-1:0]   sample_out
);

    import ltp_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;   // index compare width
    localparam int PW = FRAC_BITS + IDX_W;                     // phase width
    localparam int FW = FRAC_BITS + 1;                         // fraction incl. 1.0

    localparam logic signed [PW-1:0] PHASE_RST =
        $signed({{(IDX_W-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}});
    // lowest reachable phase: loop_end = 0 gives -3.0
    localparam logic signed [PW-1:0] PHASE_FLOOR =
        $signed({{(IDX_W-2){1'b1}}, 2'b01, {FRAC_BITS{1'b0}}});
    localparam logic [FW-1:0] ONE_F = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_INDEX,
        ST_READ,
        ST_LAUNCH,
        ST_CALC,
        ST_ZERO
    } state_t;

    // control
    state_t                 state_reg;
    logic [1:0]             cnt_reg;
    logic signed [PW-1:0]   phase_reg;
    logic                   out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;

    // configuration
    logic [LEN_W-1:0]       table_length_reg;
    logic [LSTART_W-1:0]    loop_start_reg;
    logic [LEND_W-1:0]      loop_end_reg;

    // datapath
    logic signed [PW-1:0]   sum_reg;
    logic [AW-1:0]          base_reg;
    logic [FW-1:0]          f_reg;
    logic signed [SAMPLE_W-1:0] a_reg, b_reg, c_reg;

    logic                   in_accept, out_free, addr_ok, ram_we, play_short;
    logic [AW-1:0]          ram_addr;
    logic [SAMPLE_W-1:0]    ram_rdata;
    logic [IW-1:0]          len_x, maxi_x, ip_x, ip_sel;
    logic [FW-1:0]          f_next;
    logic [AW-1:0]          base_next;
    logic [IDX_W-1:0]       lo_int;
    logic signed [IDX_W-1:0] hi_int;
    logic signed [PW-1:0]   lo_ph, hi_ph, speed_x, wrap1, phase_next;
    logic                   cub_start, cub_take, cub_done;
    logic signed [SAMPLE_W-1:0] cub_y;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    assign addr_ok = (IW'(address) < IW'(TABLE_DEPTH));
    assign ram_we  = in_accept && (op == OP_WRITE) && addr_ok;
    assign ram_addr = (state_reg == ST_READ) ? base_reg + AW'(cnt_reg) : AW'(address);

    assign cub_start = (state_reg == ST_LAUNCH);
    assign cub_take  = (state_reg == ST_CALC) && cub_done && out_free;

    always_comb
    begin
        // effective length, saturated to the table depth
        len_x      = (IW'(table_length_reg) > IW'(TABLE_DEPTH)) ?
                     IW'(TABLE_DEPTH) : IW'(table_length_reg);
        play_short = (len_x < IW'(3));
        maxi_x     = len_x - IW'(3);

        // loop bounds in phase units
        lo_int  = {{(IDX_W-LSTART_W){1'b0}}, loop_start_reg} + IDX_W'(1);
        hi_int  = $signed({{(IDX_W-LEND_W){1'b0}}, loop_end_reg}) - $signed(IDX_W'(3));
        lo_ph   = $signed({lo_int, {FRAC_BITS{1'b0}}});
        hi_ph   = $signed({hi_int, {FRAC_BITS{1'b0}}});
        speed_x = $signed({{(PW-SPEED_W){speed[SPEED_W-1]}}, speed});

        // loop checks, in order
        wrap1      = (sum_reg < lo_ph) ? hi_ph : sum_reg;
        phase_next = (wrap1 > hi_ph) ? lo_ph : wrap1;

        // integer part clamp; a negative phase counts as zero
        ip_x = phase_reg[PW-1] ? '0 : IW'(phase_reg[PW-1:FRAC_BITS]);
        if (ip_x == '0)
        begin
            ip_sel = IW'(1);
            f_next = '0;
        end
        else if (ip_x > maxi_x)
        begin
            ip_sel = maxi_x;
            f_next = ONE_F;
        end
        else
        begin
            ip_sel = ip_x;
            f_next = {1'b0, phase_reg[FRAC_BITS-1:0]};
        end
        base_next = AW'(ip_sel - IW'(1));
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_length_reg <= TABLE_LENGTH_RST;
            loop_start_reg   <= LOOP_START_RST;
            loop_end_reg     <= LOOP_END_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TABLE_LENGTH: table_length_reg <= cfg_data[LEN_W-1:0];
                CFG_LOOP_START:   loop_start_reg   <= cfg_data[LSTART_W-1:0];
                CFG_LOOP_END:     loop_end_reg     <= cfg_data[LEND_W-1:0];
                default:          ;
            endcase
        end
    end

    // Sequencer, phase and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            phase_reg      <= PHASE_RST;
            out_valid_reg  <= 1'b0;
            sample_out_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && (op == OP_PLAY))
                    begin
                        state_reg <= play_short ? ST_ZERO : ST_WRAP;
                    end
                end
                ST_WRAP:
                begin
                    phase_reg <= phase_next;
                    state_reg <= ST_INDEX;
                end
                ST_INDEX:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                    begin
                        state_reg <= ST_LAUNCH;
                    end
                end
                ST_LAUNCH:
                begin
                    state_reg <= ST_CALC;
                end
                ST_CALC:
                begin
                    if (cub_take)
                    begin
                        out_valid_reg  <= 1'b1;
                        sample_out_reg <= cub_y;
                        state_reg      <= ST_IDLE;
                    end
                end
                ST_ZERO:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        sample_out_reg <= '0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Phase sum, clamped index and fetched neighbors
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sum_reg <= phase_reg + speed_x;
        end
        if (state_reg == ST_INDEX)
        begin
            base_reg <= base_next;
            f_reg    <= f_next;
        end
        if (state_reg == ST_READ)
        begin
            // read data arrives in the cycle after its address
            case (cnt_reg)
                2'd1:    a_reg <= ram_rdata;
                2'd2:    b_reg <= ram_rdata;
                2'd3:    c_reg <= ram_rdata;
                default: ;
            endcase
        end
    end

    ltp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (sample_in),
        .rdata (ram_rdata)
    );

    // d comes straight from the RAM in the launch cycle
    ltp_cubic #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cubic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cub_start),
        .take  (cub_take),
        .a     (a_reg),
        .b     (b_reg),
        .c     (c_reg),
        .d     ($signed(ram_rdata)),
        .f     (f_reg),
        .done  (cub_done),
        .y     (cub_y)
    );

`ifndef SYNTH
    a_read_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (IW'(ram_addr) < IW'(TABLE_DEPTH)))
        else $error("table read beyond depth");

    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        cub_done |-> (state_reg == ST_CALC))
        else $error("interpolation result outside calc state");

    a_play_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (op == OP_PLAY)) |=> in_stall)
        else $error("play item did not block input");

    a_phase_floor: assert property (@(posedge clk) disable iff (!rst_n)
        !(phase_reg < PHASE_FLOOR))
        else $error("phase below lowest loop bound");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past((state_reg == ST_CALC) || (state_reg == ST_ZERO)))
        else $error("result without a play item");
`endif

endmodule
